// ----- sv/i2d_pkg.sv -----
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2d_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int WIDE_W  = 36;   // room for nine times the top power of ten

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // decimal powers, 10^0 up to 10^9
    localparam int                NUM_POW   = 10;
    localparam int                POW_IDX_W = 4;
    localparam logic [POW_IDX_W-1:0] TOP_POW_IDX = 4'd9;
    localparam logic [POW_IDX_W-1:0] LOW_POW_IDX = 4'd0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = 1;
    localparam int CNT_W       = 2;

    // one classified beat: sign flag and unsigned magnitude
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    // write side of the queue
    typedef struct packed {
        logic  push;
        t_item item;
    } t_push;

    // back end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_DIGITS
    } t_state;

    // power of ten for a digit position
    function automatic logic [VALUE_W-1:0] pow10(input logic [POW_IDX_W-1:0] idx);
        logic [VALUE_W-1:0] p;
        unique case (idx)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- sv/i2d_front.sv -----
// ----------------------------------------------------------------------------
// i2d_front
// Accepts signed values, splits them into sign and magnitude and hands the
// classified beat to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_front (
    input  wire logic                          i_start,
    input  wire logic [i2d_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_full,
    output logic                               o_busy,
    output i2d_pkg::t_push                     o_push
);

    logic neg;

    // hold off new beats while the queue has no room
    assign o_busy = i_full;

    // sign and magnitude; the most negative value wraps to 2^31 unsigned
    assign neg = i_value[i2d_pkg::VALUE_W-1];

    always_comb begin
        o_push.push     = i_start & ~i_full;
        o_push.item.neg = neg;
        o_push.item.mag = neg ? (~i_value + 32'd1) : i_value;
    end

endmodule

`default_nettype wire

// ----- sv/i2d_queue.sv -----
// ----------------------------------------------------------------------------
// i2d_queue
// Short queue of classified beats between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire i2d_pkg::t_push     i_push,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_valid,
    output i2d_pkg::t_item          o_item
);

    i2d_pkg::t_item                 r_mem [i2d_pkg::QUEUE_DEPTH];
    logic [i2d_pkg::PTR_W-1:0]      r_wr_ptr;
    logic [i2d_pkg::PTR_W-1:0]      r_rd_ptr;
    logic [i2d_pkg::CNT_W-1:0]      r_count;
    logic [i2d_pkg::PTR_W-1:0]      n_wr_ptr;
    logic [i2d_pkg::PTR_W-1:0]      n_rd_ptr;
    logic [i2d_pkg::CNT_W-1:0]      n_count;
    logic                           do_pop;

    assign o_full  = (r_count == i2d_pkg::CNT_W'(i2d_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push.push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push.push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.push)
        else $error("queue written while full");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i2d_pkg::CNT_W'(i2d_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

// ----- sv/i2d_back.sv -----
// ----------------------------------------------------------------------------
// i2d_back
// Takes beats from the queue and emits the decimal text a character at a time:
// optional minus sign, then one power of ten per cycle from 10^9 down,
// leading zeros dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire i2d_pkg::t_item                i_item,
    output logic                               o_pop,
    output logic                               o_strobe,
    output logic [i2d_pkg::CHAR_W-1:0]         o_character,
    output logic                               o_last
);

    i2d_pkg::t_state                    r_state;
    i2d_pkg::t_state                    n_state;
    logic [i2d_pkg::VALUE_W-1:0]        r_rem;
    logic [i2d_pkg::VALUE_W-1:0]        n_rem;
    logic [i2d_pkg::VALUE_W-1:0]        r_pow_val;
    logic [i2d_pkg::VALUE_W-1:0]        n_pow_val;
    logic [i2d_pkg::POW_IDX_W-1:0]      r_pow;
    logic [i2d_pkg::POW_IDX_W-1:0]      n_pow;
    logic                               r_started;
    logic                               n_started;
    logic                               r_strobe;
    logic                               n_strobe;
    logic [i2d_pkg::CHAR_W-1:0]         r_char;
    logic [i2d_pkg::CHAR_W-1:0]         n_char;
    logic                               r_last;
    logic                               n_last;

    logic [i2d_pkg::WIDE_W-1:0]         mult [10];
    logic [3:0]                         digit;
    logic [i2d_pkg::WIDE_W-1:0]         sel_mult;
    logic                               emit;

    // digit select: largest k with k * power not above the remainder
    always_comb begin
        digit    = 4'd0;
        sel_mult = '0;
        for (int k = 0; k < 10; k++) begin
            mult[k] = {4'd0, r_pow_val} * i2d_pkg::WIDE_W'(k);
        end
        for (int k = 1; k < 10; k++) begin
            if ({4'd0, r_rem} >= mult[k]) begin
                digit    = 4'(k);
                sel_mult = mult[k];
            end
        end
    end

    // emit once a non-zero digit is seen, and always on the units digit
    assign emit = r_started | (digit != 4'd0) | (r_pow == i2d_pkg::LOW_POW_IDX);

    // sequencer next state and outputs
    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_pow_val = r_pow_val;
        n_pow     = r_pow;
        n_started = r_started;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;
        o_pop     = 1'b0;
        unique case (r_state)
            i2d_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_rem     = i_item.mag;
                    n_pow     = i2d_pkg::TOP_POW_IDX;
                    n_pow_val = i2d_pkg::pow10(i2d_pkg::TOP_POW_IDX);
                    n_started = 1'b0;
                    n_strobe  = i_item.neg;
                    n_char    = i2d_pkg::ASCII_MINUS;
                    n_state   = i2d_pkg::ST_DIGITS;
                end
            end
            i2d_pkg::ST_DIGITS: begin
                n_strobe  = emit;
                n_char    = i2d_pkg::ASCII_ZERO + i2d_pkg::CHAR_W'(digit);
                n_last    = (r_pow == i2d_pkg::LOW_POW_IDX);
                n_started = emit;
                n_rem     = r_rem - sel_mult[i2d_pkg::VALUE_W-1:0];
                if (r_pow == i2d_pkg::LOW_POW_IDX) begin
                    n_state = i2d_pkg::ST_IDLE;
                end else begin
                    n_pow     = r_pow - 1'b1;
                    n_pow_val = i2d_pkg::pow10(r_pow - 1'b1);
                end
            end
            default: begin
                n_state = i2d_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2d_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_pow_val <= n_pow_val;
        r_pow     <= n_pow;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_last_ends_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (r_state == i2d_pkg::ST_IDLE))
        else $error("final character while digits still pending");

    a_more_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (r_state == i2d_pkg::ST_DIGITS))
        else $error("run ended without a final character");

    a_rem_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2d_pkg::ST_DIGITS) |-> ({4'd0, r_rem} < mult[1] * 36'd10))
        else $error("remainder too large for the current digit position");
`endif

endmodule

`default_nettype wire

// ----- sv/int32_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// an accepted value is written into the queue and popped by the idle back end,
//   which registers its text; leading zero slots leave gaps after a minus sign
// the back end takes a new value only once its digit loop is through the sign
//   slot and each power of ten
// a two-entry queue takes up to two further values; the receiver cannot stall
// synchronous active-low reset empties the queue and idles the sequencer
`default_nettype none

module int32_to_decimal_ascii (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [i2d_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_strobe,
    output logic [i2d_pkg::CHAR_W-1:0]         o_character,
    output logic                               o_last
);

    i2d_pkg::t_push  push;
    i2d_pkg::t_item  q_item;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    // front: classify incoming beats
    i2d_front u_front (
        .i_start (start),
        .i_value (i_value),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (push)
    );

    // queue between front and back
    i2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: digit generation
    i2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ----- bench/decimal_text_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// decimal_text_tracker_pkg
// Expected character store for the integer to decimal text converter: works
// out the text of each accepted value and compares the character beats.
// ----------------------------------------------------------------------------
package decimal_text_tracker_pkg;

    // one expected character beat
    typedef struct packed {
        logic [i2d_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_char_beat;

    class decimal_text_tracker;

        t_char_beat  expected_chars[$];
        int unsigned mismatches;
        int unsigned values_noted;
        int unsigned negatives_noted;
        int unsigned full_width_noted;
        int unsigned chars_checked;

        function new();
            mismatches       = 0;
            values_noted     = 0;
            negatives_noted  = 0;
            full_width_noted = 0;
            chars_checked    = 0;
        endfunction

        // build the decimal text of an accepted value
        function void note_value(logic [i2d_pkg::VALUE_W-1:0] value);
            logic                        neg;
            logic [i2d_pkg::VALUE_W-1:0] magnitude;
            logic [i2d_pkg::CHAR_W-1:0]  text[$];
            t_char_beat                  beat;

            neg       = value[i2d_pkg::VALUE_W-1];
            magnitude = neg ? (~value + 1'b1) : value;
            // digits from least significant, placed at the front
            do begin
                text.push_front(i2d_pkg::CHAR_W'(magnitude % 10) + i2d_pkg::ASCII_ZERO);
                magnitude = magnitude / 10;
            end while (magnitude != 0);
            if (neg) begin
                text.push_front(i2d_pkg::ASCII_MINUS);
                negatives_noted++;
            end
            if (text.size() == 11)
                full_width_noted++;
            foreach (text[k]) begin
                beat.code = text[k];
                beat.last = (k == text.size() - 1);
                expected_chars.push_back(beat);
            end
            values_noted++;
        endfunction

        // compare one character beat with the oldest expected one
        function void check_char(logic [i2d_pkg::CHAR_W-1:0] code, logic last);
            t_char_beat want;

            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected character %0d last %0b", $time, code, last);
                return;
            end
            want = expected_chars.pop_front();
            if (code !== want.code || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] character mismatch: expected %0d last %0b, got %0d last %0b",
                             $time, want.code, want.last, code, last);
            end
        endfunction

        function int unsigned outstanding();
            return expected_chars.size();
        endfunction

    endclass

endpackage

// ----- bench/int32_to_decimal_ascii_tb.sv -----
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_tb
// Drives signed values into the decimal text converter in bursts with random
// gaps, predicts each value's character beats and checks them in order.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_VALUES = 500;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [i2d_pkg::VALUE_W-1:0]  i_value;
    logic                         o_strobe;
    logic [i2d_pkg::CHAR_W-1:0]   o_character;
    logic                         o_last;

    decimal_text_tracker_pkg::decimal_text_tracker text_board;
    int unsigned         cycle_count;

    int directed_vals[] = '{0, 1, -1, 9, -9, 10, -10, 99, -100, 12345, -67890,
                            999999999, -999999999, 1000000000, -1000000000,
                            2147483647, -2147483647, -2147483647 - 1,
                            int'(32'h5555_5555), int'(32'hAAAA_AAAA)};

    int32_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // character beats are checked as they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            text_board.check_char(o_character, o_last);
    end

    // random value: by digit count, raw, small, near the limits or near 10^n
    function automatic logic [i2d_pkg::VALUE_W-1:0] pick_value();
        int unsigned  kind;
        int unsigned  digits;
        longint       low_bound;
        longint       high_bound;
        logic [i2d_pkg::VALUE_W-1:0] magnitude;

        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                digits    = $urandom_range(1, 10);
                low_bound = 1;
                repeat (digits - 1) low_bound = low_bound * 10;
                high_bound = low_bound * 10 - 1;
                if (digits == 1) low_bound = 0;
                if (high_bound > 64'd2147483648) high_bound = 64'd2147483648;
                magnitude = $urandom_range(int'(high_bound), int'(low_bound));
                return $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
            end
            4, 5, 6: return $urandom();
            7:       return i2d_pkg::VALUE_W'($urandom_range(0, 40)) - 20;
            8: begin
                if ($urandom_range(0, 1))
                    return 32'h7FFF_FFFF - $urandom_range(0, 15);
                return 32'h8000_0000 + $urandom_range(0, 15);
            end
            default: begin
                magnitude = 1;
                repeat ($urandom_range(0, 9)) magnitude = magnitude * 10;
                magnitude = magnitude + $urandom_range(0, 2) - 1;
                return $urandom_range(0, 1) ? (~magnitude + 1'b1) : magnitude;
            end
        endcase
    endfunction

    // present one value and hold it until taken; start stays high afterwards
    task automatic send_value(input logic [i2d_pkg::VALUE_W-1:0] value);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        text_board.note_value(value);
    endtask

    // idle the sender for some cycles, with noise on the value lines
    task automatic idle_sender(input int unsigned cycles);
        if (cycles == 0) return;
        @(negedge i_clk);
        start   <= 1'b0;
        i_value <= $urandom();
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // hold off until every expected character beat is in
    task automatic drain_text();
        @(negedge i_clk);
        start <= 1'b0;
        while (text_board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;

        text_board  = new();
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = '0;

        // hold reset low, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed extremes, back to back then spaced
        foreach (directed_vals[k]) begin
            send_value(directed_vals[k]);
            if (k >= 10) idle_sender($urandom_range(0, 12));
        end
        drain_text();

        // random bursts, one stretch with no gaps and one full drain
        sent = 0;
        while (sent < RANDOM_VALUES) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                send_value(pick_value());
                sent++;
            end
            if (sent >= 150 && sent < 220)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = 0;
            else
                gap = $urandom_range(1, 25);
            if (sent >= 300 && sent < 300 + burst)
                drain_text();
            else
                idle_sender(gap);
        end

        drain_text();

        $display("converted %0d values (%0d negative, %0d of full width), %0d characters checked",
                 text_board.values_noted, text_board.negatives_noted,
                 text_board.full_width_noted, text_board.chars_checked);
        $display("mismatches: %0d, characters still owed: %0d",
                 text_board.mismatches, text_board.outstanding());
        if (text_board.mismatches == 0 && text_board.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
